[rtl/core/gcb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcb_pkg
// Types, fixed-point constants and helper functions for the great-circle
// bearing unit.
// ----------------------------------------------------------------------------
package gcb_pkg;

   localparam int ANG_W   = 34;
   localparam int CS_W    = 34;
   localparam int MAG_W   = 34;
   localparam int VEC_W   = 37;
   localparam int Q_BITS  = 30;
   localparam int TAB_LEN = 32;
   localparam int BRG_W   = 16;
   localparam int SUM_W   = 32;
   localparam int PRE_SH  = 5;
   localparam int RCP_W   = 29;
   localparam int RCP_SH  = 40;
   localparam int PROD_W  = SUM_W - PRE_SH + RCP_W;

   localparam logic signed [ANG_W-1:0] DEG90  = 34'sd900000000;
   localparam logic signed [ANG_W-1:0] DEG180 = 34'sd1800000000;
   localparam logic signed [ANG_W-1:0] DEG360 = 34'sd3600000000;
   localparam logic signed [CS_W-1:0]  INV_GAIN_Q30 = 34'sd652032874;

   localparam logic [SUM_W-1:0] B_DEG90    = 32'd900000000;
   localparam logic [SUM_W-1:0] B_DEG180   = 32'd1800000000;
   localparam logic [SUM_W-1:0] B_DEG270   = 32'd2700000000;
   localparam logic [SUM_W-1:0] B_DEG360   = 32'd3600000000;
   localparam logic [SUM_W-1:0] ROUND_HALF = 32'd50000;
   localparam logic [RCP_W-1:0] RECIP_M    = 29'd351843721;
   localparam logic [BRG_W-1:0] FULL_TURN  = 16'd36000;

   typedef struct packed {
      logic lon_gt;
      logic lon_lt;
      logic lat_gt;
      logic lat_lt;
   } side_type;

   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic signed [ANG_W-1:0] r;
      case (idx)
         0:  r = 34'sd450000000;
         1:  r = 34'sd265650512;
         2:  r = 34'sd140362435;
         3:  r = 34'sd71250163;
         4:  r = 34'sd35763344;
         5:  r = 34'sd17899106;
         6:  r = 34'sd8951737;
         7:  r = 34'sd4476142;
         8:  r = 34'sd2238105;
         9:  r = 34'sd1119057;
         10: r = 34'sd559529;
         11: r = 34'sd279765;
         12: r = 34'sd139882;
         13: r = 34'sd69941;
         14: r = 34'sd34971;
         15: r = 34'sd17485;
         16: r = 34'sd8743;
         17: r = 34'sd4371;
         18: r = 34'sd2186;
         19: r = 34'sd1093;
         20: r = 34'sd546;
         21: r = 34'sd273;
         22: r = 34'sd137;
         23: r = 34'sd68;
         24: r = 34'sd34;
         25: r = 34'sd17;
         26: r = 34'sd9;
         27: r = 34'sd4;
         28: r = 34'sd2;
         29: r = 34'sd1;
         30: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Bring an angle into [-180, 180) degrees.
   function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] a);
      logic signed [ANG_W-1:0] r;
      r = a;
      if (r >= DEG360) begin
         r = r - DEG360;
      end else if (r <= -DEG360) begin
         r = r + DEG360;
      end
      if (r >= DEG180) begin
         r = r - DEG360;
      end
      if (r < -DEG180) begin
         r = r + DEG360;
      end
      return r;
   endfunction

   function automatic logic [MAG_W-1:0] abs_cs(input logic signed [CS_W-1:0] v);
      return v[CS_W-1] ? MAG_W'(-v) : MAG_W'(v);
   endfunction

endpackage
`default_nettype wire

[rtl/core/great_circle_bearing_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// great_circle_bearing_unit
// Initial great-circle bearing between two positions, in centidegrees.
// ----------------------------------------------------------------------------
// Fully pipelined: one coordinate pair is taken per cycle while the result
// channel does not stall. The pipeline is made of the two CORDIC chains
// (rotation for the three sines/cosines, vectoring for the arctangent), one
// stage per iteration, plus the multiply, rounding and reciprocal-divide
// stages. A stall on the result channel freezes the whole pipeline;
// nothing is lost or repeated. Longitudes are compared raw, with no wrap
// at 180 degrees.
module great_circle_bearing_unit
   import gcb_pkg::*;
#(
   parameter int CORDIC_STAGES = 24
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire  signed [30:0]        req_from_lat,
   input  wire  signed [31:0]        req_from_lon,
   input  wire  signed [30:0]        req_to_lat,
   input  wire  signed [31:0]        req_to_lon,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic        [BRG_W-1:0]   rsp_bearing_centideg
);

   localparam int NS = CORDIC_STAGES;

   logic adv;
   logic rsp_valid_ff;
   logic [BRG_W-1:0] rsp_bearing_ff;

   assign adv                  = !(rsp_valid_ff && rsp_stall);
   assign req_stall            = !adv;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bearing_centideg = rsp_bearing_ff;

   // input register
   logic in_vld_ff;
   logic signed [ANG_W-1:0] in_lat1_ff, in_lat2_ff, in_lon1_ff, in_lon2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_lat1_ff <= ANG_W'(req_from_lat);
         in_lat2_ff <= ANG_W'(req_to_lat);
         in_lon1_ff <= ANG_W'(req_from_lon);
         in_lon2_ff <= ANG_W'(req_to_lon);
      end
   end

   // wrap stage
   logic wr_vld_ff;
   side_type wr_side_ff;
   logic signed [ANG_W-1:0] wr_ang_ff [3];
   side_type wr_side_in;

   always_comb begin
      wr_side_in.lon_gt = in_lon2_ff > in_lon1_ff;
      wr_side_in.lon_lt = in_lon2_ff < in_lon1_ff;
      wr_side_in.lat_gt = in_lat2_ff > in_lat1_ff;
      wr_side_in.lat_lt = in_lat2_ff < in_lat1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_vld_ff <= 1'b0;
      end else if (adv) begin
         wr_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wr_side_ff <= wr_side_in;
         wr_ang_ff[0] <= wrap_angle(in_lat1_ff);
         wr_ang_ff[1] <= wrap_angle(in_lat2_ff);
         wr_ang_ff[2] <= wrap_angle(in_lon2_ff - in_lon1_ff);
      end
   end

   // fold stage and rotation CORDIC; index 0 is the fold register
   logic                    rot_vld_ff  [NS+1];
   side_type                rot_side_ff [NS+1];
   logic signed [CS_W-1:0]  rot_x_ff    [NS+1][3];
   logic signed [CS_W-1:0]  rot_y_ff    [NS+1][3];
   logic signed [ANG_W-1:0] rot_z_ff    [NS+1][3];
   logic                    rot_flip_ff [NS+1][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         rot_vld_ff[0] <= wr_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_side_ff[0] <= wr_side_ff;
         for (int c = 0; c < 3; c++) begin
            rot_x_ff[0][c] <= INV_GAIN_Q30;
            rot_y_ff[0][c] <= '0;
            if (wr_ang_ff[c] > DEG90) begin
               rot_z_ff[0][c]    <= wr_ang_ff[c] - DEG180;
               rot_flip_ff[0][c] <= 1'b1;
            end else if (wr_ang_ff[c] < -DEG90) begin
               rot_z_ff[0][c]    <= wr_ang_ff[c] + DEG180;
               rot_flip_ff[0][c] <= 1'b1;
            end else begin
               rot_z_ff[0][c]    <= wr_ang_ff[c];
               rot_flip_ff[0][c] <= 1'b0;
            end
         end
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) begin
            rot_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            rot_vld_ff[i+1] <= rot_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rot_side_ff[i+1] <= rot_side_ff[i];
            for (int c = 0; c < 3; c++) begin
               rot_flip_ff[i+1][c] <= rot_flip_ff[i][c];
               if (!rot_z_ff[i][c][ANG_W-1]) begin
                  rot_x_ff[i+1][c] <= rot_x_ff[i][c] - (rot_y_ff[i][c] >>> i);
                  rot_y_ff[i+1][c] <= rot_y_ff[i][c] + (rot_x_ff[i][c] >>> i);
                  rot_z_ff[i+1][c] <= rot_z_ff[i][c] - atan_entry(i);
               end else begin
                  rot_x_ff[i+1][c] <= rot_x_ff[i][c] + (rot_y_ff[i][c] >>> i);
                  rot_y_ff[i+1][c] <= rot_y_ff[i][c] - (rot_x_ff[i][c] >>> i);
                  rot_z_ff[i+1][c] <= rot_z_ff[i][c] + atan_entry(i);
               end
            end
         end
      end
   end

   // sign/magnitude of sines (0..2) and cosines (3..5)
   logic mg_vld_ff;
   side_type mg_side_ff;
   logic [MAG_W-1:0] mg_mag_ff [6];
   logic             mg_neg_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         mg_vld_ff <= 1'b0;
      end else if (adv) begin
         mg_vld_ff <= rot_vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mg_side_ff <= rot_side_ff[NS];
         for (int c = 0; c < 3; c++) begin
            mg_mag_ff[c]   <= abs_cs(rot_y_ff[NS][c]);
            mg_neg_ff[c]   <= rot_y_ff[NS][c][CS_W-1] ^ rot_flip_ff[NS][c];
            mg_mag_ff[c+3] <= abs_cs(rot_x_ff[NS][c]);
            mg_neg_ff[c+3] <= rot_x_ff[NS][c][CS_W-1] ^ rot_flip_ff[NS][c];
         end
      end
   end

   // products: num = sd*c2, p2 = c1*s2, p3 = s1*c2
   logic m1_vld_ff;
   side_type m1_side_ff;
   logic [MAG_W-1:0] m1_num_ff, m1_p2_ff, m1_p3_ff, m1_cd_ff;
   logic             m1_p2_neg_ff, m1_p3_neg_ff, m1_cd_neg_ff;
   logic [2*MAG_W-1:0] pr_num, pr_p2, pr_p3;

   assign pr_num = mg_mag_ff[2] * mg_mag_ff[4];
   assign pr_p2  = mg_mag_ff[3] * mg_mag_ff[1];
   assign pr_p3  = mg_mag_ff[0] * mg_mag_ff[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff <= mg_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_side_ff   <= mg_side_ff;
         m1_num_ff    <= pr_num[Q_BITS +: MAG_W];
         m1_p2_ff     <= pr_p2[Q_BITS +: MAG_W];
         m1_p3_ff     <= pr_p3[Q_BITS +: MAG_W];
         m1_p2_neg_ff <= mg_neg_ff[3] ^ mg_neg_ff[1];
         m1_p3_neg_ff <= mg_neg_ff[0] ^ mg_neg_ff[4];
         m1_cd_ff     <= mg_mag_ff[5];
         m1_cd_neg_ff <= mg_neg_ff[5];
      end
   end

   // p4 = p3*cd
   logic m2_vld_ff;
   side_type m2_side_ff;
   logic [MAG_W-1:0] m2_num_ff, m2_p2_ff, m2_p4_ff;
   logic             m2_p2_neg_ff, m2_p4_neg_ff;
   logic [2*MAG_W-1:0] pr_p4;

   assign pr_p4 = m1_p3_ff * m1_cd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else if (adv) begin
         m2_vld_ff <= m1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_side_ff   <= m1_side_ff;
         m2_num_ff    <= m1_num_ff;
         m2_p2_ff     <= m1_p2_ff;
         m2_p2_neg_ff <= m1_p2_neg_ff;
         m2_p4_ff     <= pr_p4[Q_BITS +: MAG_W];
         m2_p4_neg_ff <= m1_p3_neg_ff ^ m1_cd_neg_ff;
      end
   end

   // den = p2 - p4
   logic m3_vld_ff;
   side_type m3_side_ff;
   logic [MAG_W-1:0] m3_num_ff;
   logic signed [VEC_W-1:0] m3_den_ff;
   logic signed [VEC_W-1:0] p2_s, p4_s;

   assign p2_s = m2_p2_neg_ff ? -VEC_W'(m2_p2_ff) : VEC_W'(m2_p2_ff);
   assign p4_s = m2_p4_neg_ff ? -VEC_W'(m2_p4_ff) : VEC_W'(m2_p4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_vld_ff <= 1'b0;
      end else if (adv) begin
         m3_vld_ff <= m2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m3_side_ff <= m2_side_ff;
         m3_num_ff  <= m2_num_ff;
         m3_den_ff  <= p2_s - p4_s;
      end
   end

   // vectoring CORDIC; index 0 holds |den|, |num|
   logic                    vec_vld_ff  [NS+1];
   side_type                vec_side_ff [NS+1];
   logic                    vec_zero_ff [NS+1];
   logic signed [VEC_W-1:0] vec_x_ff    [NS+1];
   logic signed [VEC_W-1:0] vec_y_ff    [NS+1];
   logic signed [ANG_W-1:0] vec_z_ff    [NS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vec_vld_ff[0] <= m3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_side_ff[0] <= m3_side_ff;
         vec_zero_ff[0] <= (m3_num_ff == '0);
         vec_x_ff[0]    <= m3_den_ff[VEC_W-1] ? -m3_den_ff : m3_den_ff;
         vec_y_ff[0]    <= VEC_W'(m3_num_ff);
         vec_z_ff[0]    <= '0;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (reset) begin
            vec_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vec_vld_ff[i+1] <= vec_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            vec_side_ff[i+1] <= vec_side_ff[i];
            vec_zero_ff[i+1] <= vec_zero_ff[i];
            if (!vec_y_ff[i][VEC_W-1]) begin
               vec_x_ff[i+1] <= vec_x_ff[i] + (vec_y_ff[i] >>> i);
               vec_y_ff[i+1] <= vec_y_ff[i] - (vec_x_ff[i] >>> i);
               vec_z_ff[i+1] <= vec_z_ff[i] + atan_entry(i);
            end else begin
               vec_x_ff[i+1] <= vec_x_ff[i] - (vec_y_ff[i] >>> i);
               vec_y_ff[i+1] <= vec_y_ff[i] + (vec_x_ff[i] >>> i);
               vec_z_ff[i+1] <= vec_z_ff[i] - atan_entry(i);
            end
         end
      end
   end

   // clamp arctangent to 0..90 degrees
   logic f1_vld_ff;
   side_type f1_side_ff;
   logic signed [ANG_W-1:0] f1_a_ff;
   logic signed [ANG_W-1:0] zv;

   assign zv = vec_z_ff[NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff <= vec_vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_side_ff <= vec_side_ff[NS];
         if (vec_zero_ff[NS] || zv[ANG_W-1]) begin
            f1_a_ff <= '0;
         end else if (zv > DEG90) begin
            f1_a_ff <= DEG90;
         end else begin
            f1_a_ff <= zv;
         end
      end
   end

   // quadrant select plus rounding offset
   logic f2_vld_ff;
   logic f2_lon_eq_ff;
   logic [SUM_W-1:0] f2_sum_ff;
   logic [SUM_W-1:0] a_u, b_sel;

   assign a_u = SUM_W'(f1_a_ff);

   always_comb begin
      if (f1_side_ff.lon_gt) begin
         if (f1_side_ff.lat_gt) begin
            b_sel = a_u;
         end else if (f1_side_ff.lat_lt) begin
            b_sel = B_DEG180 - a_u;
         end else begin
            b_sel = B_DEG90;
         end
      end else if (f1_side_ff.lon_lt) begin
         if (f1_side_ff.lat_gt) begin
            b_sel = B_DEG360 - a_u;
         end else if (f1_side_ff.lat_lt) begin
            b_sel = B_DEG180 + a_u;
         end else begin
            b_sel = B_DEG270;
         end
      end else begin
         b_sel = f1_side_ff.lat_lt ? B_DEG180 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_vld_ff <= 1'b0;
      end else if (adv) begin
         f2_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_lon_eq_ff <= !f1_side_ff.lon_gt && !f1_side_ff.lon_lt;
         f2_sum_ff    <= b_sel + ROUND_HALF;
      end
   end

   // divide by 100000 as >>5 then reciprocal of 3125
   logic q1_vld_ff;
   logic [PROD_W-1:0] q1_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_vld_ff <= 1'b0;
      end else if (adv) begin
         q1_vld_ff <= f2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_prod_ff <= f2_sum_ff[SUM_W-1:PRE_SH] * RECIP_M;
      end
   end

   logic [BRG_W-1:0] quot;

   assign quot = q1_prod_ff[RCP_SH +: BRG_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= q1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_bearing_ff <= (quot >= FULL_TURN) ? '0 : quot;
      end
   end

   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_bearing_ff < FULL_TURN)
      else $error("bearing out of range");

   a_atan_clamped: assert property (@(posedge clock) disable iff (reset)
      f1_vld_ff |-> (!f1_a_ff[ANG_W-1] && f1_a_ff <= DEG90))
      else $error("arctangent outside first quadrant");

   a_meridian: assert property (@(posedge clock) disable iff (reset)
      (f2_vld_ff && f2_lon_eq_ff) |->
         (f2_sum_ff == ROUND_HALF || f2_sum_ff == B_DEG180 + ROUND_HALF))
      else $error("equal longitudes not north or south");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(q1_prod_ff) && $stable(q1_vld_ff)))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the great-circle bearing unit. A behavioral
// CORDIC model predicts each bearing; a scoreboard matches results in order.
// ----------------------------------------------------------------------------

class bearing_board;
   logic [15:0] pending[$];
   int errors;

   function new();
      errors = 0;
   endfunction

   function void note(logic [15:0] b);
      pending.push_back(b);
   endfunction

   function void check(logic [15:0] got);
      logic [15:0] want;
      if (pending.size() == 0) begin
         $error("unexpected transfer bearing_centideg actual %0d", got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (want !== got) begin
         $error("bearing_centideg expected %0d actual %0d", want, got);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int STAGES = 24;
   localparam longint D90 = 64'sd900000000;
   localparam longint D180 = 64'sd1800000000;
   localparam longint D360 = 64'sd3600000000;
   localparam int LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [30:0] req_from_lat = '0;
   logic signed [31:0] req_from_lon = '0;
   logic signed [30:0] req_to_lat = '0;
   logic signed [31:0] req_to_lon = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [15:0] rsp_bearing_centideg;

   bearing_board board = new();
   int cycles = 0;
   int sent_total = 0;
   longint arc_tab[32];

   great_circle_bearing_unit #(.CORDIC_STAGES(STAGES)) uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint qmul(longint a, longint b);
      longint ua, ub, p;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = (ua * ub) >> 30;
      return ((a < 0) != (b < 0)) ? -p : p;
   endfunction

   task automatic rotate(input longint ang, output longint s, output longint c);
      longint a, x, y, dx, dy;
      bit flip;
      a = ang % D360;
      x = 652032874;
      y = 0;
      flip = 0;
      if (a >= D180) a -= D360;
      if (a < -D180) a += D360;
      if (a > D90) begin a -= D180; flip = 1; end
      else if (a < -D90) begin a += D180; flip = 1; end
      for (int i = 0; i < STAGES && i < 32; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (a >= 0) begin x -= dx; y += dy; a -= arc_tab[i]; end
         else begin x += dx; y -= dy; a += arc_tab[i]; end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   function automatic longint vector_angle(longint yv, longint xv);
      longint x, y, z, dx, dy;
      x = xv < 0 ? -xv : xv;
      y = yv < 0 ? -yv : yv;
      z = 0;
      if (y == 0) return 0;
      for (int i = 0; i < STAGES && i < 32; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (y >= 0) begin x += dx; y -= dy; z += arc_tab[i]; end
         else begin x -= dx; y += dy; z -= arc_tab[i]; end
      end
      if (z < 0) z = 0;
      if (z > D90) z = D90;
      return z;
   endfunction

   task automatic predict_bearing(input longint la1, input longint lo1, input longint la2,
                                  input longint lo2, output logic [15:0] brg);
      longint s1, c1, s2, c2, sd, cd, num, den, a, b, r;
      rotate(la1, s1, c1);
      rotate(la2, s2, c2);
      rotate(lo2 - lo1, sd, cd);
      num = qmul(sd, c2);
      den = qmul(c1, s2) - qmul(qmul(s1, c2), cd);
      a = vector_angle(num, den);
      if (lo2 > lo1) b = la2 > la1 ? a : (la2 < la1 ? D180 - a : D90);
      else if (lo2 < lo1) b = la2 > la1 ? D360 - a : (la2 < la1 ? D180 + a : 3 * D90);
      else b = la2 < la1 ? D180 : 0;
      r = (b + 50000) / 100000;
      if (r >= 36000) r = 0;
      brg = r[15:0];
   endtask

   task automatic send(input logic [30:0] la1, input logic [31:0] lo1,
                       input logic [30:0] la2, input logic [31:0] lo2);
      logic [15:0] b;
      predict_bearing(longint'($signed(la1)), longint'($signed(lo1)),
                      longint'($signed(la2)), longint'($signed(lo2)), b);
      req_valid <= 1;
      req_from_lat <= la1;
      req_from_lon <= lo1;
      req_to_lat <= la2;
      req_to_lon <= lo2;
      do @(posedge clock); while (req_stall);
      board.note(b);
      @(negedge clock);
   endtask

   task automatic pause(input int n);
      req_valid <= 0;
      repeat (n) @(negedge clock);
   endtask

   function automatic bit stim_count(int n);
      sent_total += n;
      return sent_total >= 1200;
   endfunction

   function automatic longint uut_tab(int i);
      longint t[32] = '{450000000, 265650512, 140362435, 71250163, 35763344, 17899106,
                       8951737, 4476142, 2238105, 1119057, 559529, 279765, 139882,
                       69941, 34971, 17485, 8743, 4371, 2186, 1093, 546, 273, 137,
                       68, 34, 17, 9, 4, 2, 1, 1, 0};
      return t[i];
   endfunction

   function automatic logic [30:0] rand_lat();
      case ($urandom_range(0, 9))
         0: return 31'($urandom);
         1: return ($urandom_range(0, 1) ? 31'sd900000000 : -31'sd900000000);
         default: return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
      endcase
   endfunction

   function automatic logic [31:0] rand_lon();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return ($urandom_range(0, 1) ? 32'sd1800000000 : -32'sd1800000000);
         default: return 32'($signed($urandom_range(0, 32'd3600000000)) - 1800000000);
      endcase
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) board.check(rsp_bearing_centideg);
      if (cycles > LIMIT) begin
         $display("great_circle_bearing_unit verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else if ((cycles / 64) % 4 == 0) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 99) < 35);
   end

   initial begin
      logic [30:0] la;
      logic [31:0] lo;
      int burst;
      for (int i = 0; i < 32; i++) arc_tab[i] = uut_tab(i);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      send(0, 0, 0, 0);
      send(100, 200, 100, 200);
      send(0, 0, 0, 10000000);
      send(0, 10000000, 0, 0);
      send(0, 0, 10000000, 0);
      send(10000000, 0, 0, 0);
      send(0, 0, 10000000, 10000000);
      send(0, 0, -10000000, 10000000);
      send(0, 0, 10000000, -10000000);
      send(0, 0, -10000000, -10000000);
      send(900000000, 1800000000, -900000000, -1800000000);
      send(-900000000, -1800000000, 900000000, 1800000000);
      send(0, 1790000000, 0, -1790000000);
      send(10000000, 1790000000, 20000000, -1790000000);
      send(31'h3fffffff, 32'h7fffffff, 31'h40000000, 32'h80000000);
      send(31'h40000000, 32'h80000000, 31'h3fffffff, 32'h7fffffff);
      send(31'h7fffffff, 32'hffffffff, 0, 0);
      send(0, 0, 31'h7fffffff, 32'hffffffff);
      send(450000000, 0, 450000000, 1);
      send(0, 0, 1, 0);
      send(899999999, 0, 900000000, 1);
      pause(3);
      forever begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            la = rand_lat();
            lo = rand_lon();
            case ($urandom_range(0, 7))
               0: send(la, lo, la, rand_lon());
               1: send(la, lo, rand_lat(), lo);
               2: send(la, lo, 31'(la + 31'($urandom_range(0, 2000)) - 31'd1000),
                       32'(lo + 32'($urandom_range(0, 2000)) - 32'd1000));
               default: send(la, lo, rand_lat(), rand_lon());
            endcase
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
         if (stim_count(burst)) break;
      end
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (2 * STAGES + 30) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("great_circle_bearing_unit verification clean");
      else
         $display("great_circle_bearing_unit verification failed");
      $finish;
   end
endmodule

[filelist.f]
rtl/core/gcb_pkg.sv
rtl/core/great_circle_bearing_unit.sv
tb/sv/tb_top.sv
